// ===== hw/rtl/sdel_pkg.sv =====
// Shared types and constants for the sorted event list.
`timescale 1ns / 1ps
`default_nettype none
package sdel_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 24;
	localparam int ID_W     = 16;

	localparam logic [1:0] ACT_CLEAR  = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_DUMP   = 2'd2;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_CLEARED   = 3'd3,
		ST_ENTRY     = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_ROTATE = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [ID_W-1:0]  id;
	} entry_t;

	typedef struct packed {
		cell_op_t op;
		entry_t   ent;
	} cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sorted_dedup_event_list.sv =====
// Top level: sorted, de-duplicated event list built from a chain of cells.
//
//   channel  handshake              payload
//   command  start, busy            action, frame_num, row, event_id
//   result   result_valid (strobe)  status, frame_num_out, row_out, event_id_out,
//                                   entry_count, last
//
// Clear and insert each give their result in the cycle after start.
// A dump gives one entry per cycle from the head cell while the chain rotates back
// to its original order; busy is high while every entry but the last is shown.
// Reset empties the list; cell contents are not reset.
// The receiver cannot stall: each result stands for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module sorted_dedup_event_list (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           action,
	input  logic [15:0]          frame_num,
	input  logic [7:0]           row,
	input  logic [15:0]          event_id,
	output logic                 result_valid,
	output sdel_pkg::status_t    status,
	output logic [15:0]          frame_num_out,
	output logic [7:0]           row_out,
	output logic [15:0]          event_id_out,
	output logic [4:0]           entry_count,
	output logic                 last
);
	import sdel_pkg::*;

	entry_t                ent_arr [CAPACITY];
	logic [CAPACITY-1:0]   eq_vec;
	logic [CAPACITY-1:0]   gt_vec;
	logic [CAPACITY-1:0]   open_vec;
	cell_ctrl_t            ctrl;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic                  busy_q;
	logic                  result_valid_q;
	status_t               status_q;
	entry_t                out_q;
	logic                  last_q;

	logic                  accept;
	logic                  dup;
	logic                  full;
	logic                  dump_last;

	assign accept    = start && !busy_q;
	assign dup       = |eq_vec;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign dump_last = ((idx_q + CNT_W'(1)) == count_q);

	always_comb begin
		ctrl.ent = '{key: {frame_num, row}, id: event_id};
		ctrl.op  = OP_HOLD;
		if (busy_q) begin
			ctrl.op = OP_ROTATE;
		end else if (accept && action == ACT_INSERT && !dup && !full) begin
			ctrl.op = OP_INSERT;
		end else if (accept && action == ACT_DUMP && count_q != '0) begin
			ctrl.op = OP_ROTATE;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic   prev_open;
		logic   prev_gt;
		entry_t prev_ent;
		entry_t next_ent;

		if (i == 0) begin : g_first
			assign prev_open = 1'b0;
			assign prev_gt   = 1'b0;
			assign prev_ent  = '0;
		end else begin : g_mid
			assign prev_open = open_vec[i-1];
			assign prev_gt   = gt_vec[i-1];
			assign prev_ent  = ent_arr[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign next_ent = '0;
		end else begin : g_nxt
			assign next_ent = ent_arr[i+1];
		end

		sdel_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.valid     (CNT_W'(i) < count_q),
			.is_tail   (CNT_W'(i + 1) == count_q),
			.prev_open (prev_open),
			.prev_gt   (prev_gt),
			.prev_ent  (prev_ent),
			.next_ent  (next_ent),
			.head_ent  (ent_arr[0]),
			.ent       (ent_arr[i]),
			.eq        (eq_vec[i]),
			.gt        (gt_vec[i]),
			.open      (open_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			idx_q          <= '0;
			busy_q         <= 1'b0;
			result_valid_q <= 1'b0;
			status_q       <= ST_CLEARED;
			out_q          <= '0;
			last_q         <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (busy_q) begin
				result_valid_q <= 1'b1;
				status_q       <= ST_ENTRY;
				out_q          <= ent_arr[0];
				last_q         <= dump_last;
				idx_q          <= idx_q + CNT_W'(1);
				if (dump_last) begin
					busy_q <= 1'b0;
				end
			end else if (accept) begin
				case (action)
					ACT_CLEAR: begin
						count_q        <= '0;
						result_valid_q <= 1'b1;
						status_q       <= ST_CLEARED;
						out_q          <= '0;
						last_q         <= 1'b1;
					end
					ACT_INSERT: begin
						result_valid_q <= 1'b1;
						out_q          <= '0;
						last_q         <= 1'b1;
						if (dup) begin
							status_q <= ST_DUPLICATE;
						end else if (full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_INSERTED;
							count_q  <= count_q + CNT_W'(1);
						end
					end
					ACT_DUMP: begin
						result_valid_q <= 1'b1;
						if (count_q == '0) begin
							status_q <= ST_EMPTY;
							out_q    <= '0;
							last_q   <= 1'b1;
						end else begin
							status_q <= ST_ENTRY;
							out_q    <= ent_arr[0];
							last_q   <= (count_q == CNT_W'(1));
							idx_q    <= CNT_W'(1);
							busy_q   <= (count_q != CNT_W'(1));
						end
					end
					default: begin
						result_valid_q <= 1'b0;
					end
				endcase
			end
		end
	end

	assign busy          = busy_q;
	assign result_valid  = result_valid_q;
	assign status        = status_q;
	assign frame_num_out = out_q.key[KEY_W-1:8];
	assign row_out       = out_q.key[7:0];
	assign event_id_out  = out_q.id;
	assign entry_count   = 5'(count_q);
	assign last          = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored count above capacity");

	a_busy_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (count_q != '0) && (idx_q < count_q))
		else $error("dump running past the stored entries");

	a_dump_ends_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> (result_valid_q && last_q && status_q == ST_ENTRY))
		else $error("dump ended without a final entry");

	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && count_q >= CNT_W'(2)) |-> (ent_arr[0].key < ent_arr[1].key))
		else $error("head entries out of order");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sdel_cell.sv =====
// One compare-and-shift cell of the sorted list chain.
`timescale 1ns / 1ps
`default_nettype none
module sdel_cell (
	input  logic               clk,
	input  sdel_pkg::cell_ctrl_t ctrl,
	input  logic               valid,
	input  logic               is_tail,
	input  logic               prev_open,
	input  logic               prev_gt,
	input  sdel_pkg::entry_t   prev_ent,
	input  sdel_pkg::entry_t   next_ent,
	input  sdel_pkg::entry_t   head_ent,
	output sdel_pkg::entry_t   ent,
	output logic               eq,
	output logic               gt,
	output logic               open
);
	import sdel_pkg::*;

	entry_t ent_q;
	entry_t ent_d;

	assign ent  = ent_q;
	assign eq   = valid && (ent_q.key == ctrl.ent.key);
	assign gt   = valid && (ent_q.key > ctrl.ent.key);
	assign open = !valid || gt;

	always_comb begin
		ent_d = ent_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (prev_gt) begin
					ent_d = prev_ent;
				end else if (open && !prev_open) begin
					ent_d = ctrl.ent;
				end
			end
			OP_ROTATE: begin
				ent_d = is_tail ? head_ent : next_ent;
			end
			default: begin
				ent_d = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for the sorted, de-duplicated event list: directed and random commands.
`timescale 1ns / 1ps
module tb;
	import sdel_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int         N_RANDOM   = 310;

	typedef struct packed {
		status_t     status;
		logic [15:0] frame;
		logic [7:0]  row;
		logic [15:0] id;
		logic [4:0]  count;
		logic        last;
	} list_result_t;

	class event_list_model;
		logic [KEY_W-1:0] keys[CAPACITY];
		logic [ID_W-1:0]  handles[CAPACITY];
		int               count;
		list_result_t     pending[$];
		int               errors;

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function status_t insert_entry(logic [KEY_W-1:0] key, logic [ID_W-1:0] id);
			int pos;
			pos = 0;
			while (pos < count) begin
				if (keys[pos] == key)
					return ST_DUPLICATE;
				if (key < keys[pos])
					break;
				pos++;
			end
			if (count >= CAPACITY)
				return ST_FULL;
			for (int i = count; i > pos; i--) begin
				keys[i]    = keys[i-1];
				handles[i] = handles[i-1];
			end
			keys[pos]    = key;
			handles[pos] = id;
			count++;
			return ST_INSERTED;
		endfunction

		function void apply_command(logic [1:0] act, logic [15:0] fn, logic [7:0] rw,
				logic [15:0] id);
			list_result_t r;
			r      = '0;
			r.last = 1'b1;
			case (act)
				ACT_CLEAR: begin
					count    = 0;
					r.status = ST_CLEARED;
					r.count  = 5'(count);
					pending.push_back(r);
				end
				ACT_INSERT: begin
					r.status = insert_entry({fn, rw}, id);
					r.count  = 5'(count);
					pending.push_back(r);
				end
				ACT_DUMP: begin
					r.count = 5'(count);
					if (count == 0) begin
						r.status = ST_EMPTY;
						pending.push_back(r);
					end else begin
						for (int i = 0; i < count; i++) begin
							r.status = ST_ENTRY;
							r.frame  = keys[i][23:8];
							r.row    = keys[i][7:0];
							r.id     = handles[i];
							r.last   = (i == count - 1);
							pending.push_back(r);
						end
					end
				end
				default: ;
			endcase
		endfunction

		function string show(list_result_t r);
			return $sformatf("status=%0d frame=%h row=%h id=%h count=%0d last=%b",
				r.status, r.frame, r.row, r.id, r.count, r.last);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual %s",
					$time, show(got));
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.frame !== want.frame ||
					got.row !== want.row || got.id !== want.id ||
					got.count !== want.count || got.last !== want.last) begin
				errors++;
				$display("%0t: result mismatch: expected %s, actual %s",
					$time, show(want), show(got));
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  action;
	logic [15:0] frame_num;
	logic [7:0]  row;
	logic [15:0] event_id;
	logic        result_valid;
	status_t     status;
	logic [15:0] frame_num_out;
	logic [7:0]  row_out;
	logic [15:0] event_id_out;
	logic [4:0]  entry_count;
	logic        last;

	event_list_model book = new();
	logic [23:0]     used_keys[$];
	bit              no_gaps;
	int              random_items;

	sorted_dedup_event_list dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.frame_num    (frame_num),
		.row          (row),
		.event_id     (event_id),
		.result_valid (result_valid),
		.status       (status),
		.frame_num_out(frame_num_out),
		.row_out      (row_out),
		.event_id_out (event_id_out),
		.entry_count  (entry_count),
		.last         (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			book.check_result('{status, frame_num_out, row_out, event_id_out, entry_count,
				last});
	end

	task automatic issue(input logic [1:0] act, input logic [15:0] fn, input logic [7:0] rw,
			input logic [15:0] id);
		start     <= 1'b1;
		action    <= act;
		frame_num <= fn;
		row       <= rw;
		event_id  <= id;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		book.apply_command(act, fn, rw, id);
	endtask

	task automatic pause(input int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 55)
			return;
		if (roll < 90)
			pause($urandom_range(1, 3));
		else
			pause($urandom_range(4, 30));
	endtask

	function automatic logic [23:0] pick_key();
		int          mode;
		logic [15:0] fn;
		mode = $urandom_range(0, 9);
		if (mode < 2 && used_keys.size() > 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		if (mode < 6) begin
			case ($urandom_range(0, 3))
				0:       fn = 16'h0000;
				1:       fn = 16'h0001;
				2:       fn = 16'h8000;
				default: fn = 16'hffff;
			endcase
			return {fn, 8'($urandom_range(0, 3))};
		end
		return 24'($urandom);
	endfunction

	task automatic random_insert();
		logic [23:0] key;
		key = pick_key();
		used_keys.push_back(key);
		if (used_keys.size() > 64)
			void'(used_keys.pop_front());
		issue(ACT_INSERT, key[23:8], key[7:0], 16'($urandom));
		random_items++;
	endtask

	task automatic random_other(input logic [1:0] act);
		issue(act, 16'($urandom), 8'($urandom), 16'($urandom));
		if (act != ACT_UNUSED)
			random_items++;
	endtask

	initial begin
		int n;
		int roll;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		action    <= ACT_CLEAR;
		frame_num <= '0;
		row       <= '0;
		event_id  <= '0;
		no_gaps   = 1'b0;
		random_items = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty dump, extremes, ordering, duplicate, ignored action, full list
		issue(ACT_DUMP, 16'hffff, 8'hff, 16'hffff);
		issue(ACT_CLEAR, 16'h0000, 8'h00, 16'h0000);
		issue(ACT_INSERT, 16'hffff, 8'hff, 16'hffff);
		issue(ACT_INSERT, 16'h0000, 8'h00, 16'h0000);
		issue(ACT_INSERT, 16'h0000, 8'h00, 16'h5a5a);
		pause(2);
		issue(ACT_INSERT, 16'h8000, 8'h80, 16'h1234);
		issue(ACT_INSERT, 16'h8000, 8'h7f, 16'h4321);
		issue(ACT_INSERT, 16'h7fff, 8'hff, 16'hbeef);
		issue(ACT_UNUSED, 16'h8000, 8'h80, 16'hdead);
		issue(ACT_DUMP, 16'h0000, 8'h00, 16'h0000);
		for (int i = 0; i < 11; i++) begin
			issue(ACT_INSERT, 16'h1000 + 16'(i), 8'(i * 17), 16'(16'h0100 + i));
			if (i % 3 == 0)
				pause(i % 5 + 1);
		end
		issue(ACT_INSERT, 16'h4000, 8'h00, 16'haaaa);
		issue(ACT_INSERT, 16'h8000, 8'h80, 16'h5555);
		issue(ACT_DUMP, 16'hffff, 8'hff, 16'hffff);
		issue(ACT_CLEAR, 16'hffff, 8'hff, 16'hffff);

		// random: mostly clear, fill, dump sequences with some broken ones
		while (random_items < N_RANDOM) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) != 0) begin
				random_other(ACT_CLEAR);
				random_gap();
			end
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 10);
			for (int i = 0; i < n; i++) begin
				roll = $urandom_range(0, 99);
				if (roll < 86)
					random_insert();
				else if (roll < 93)
					random_other(ACT_DUMP);
				else if (roll < 97)
					random_other(ACT_UNUSED);
				else
					random_other(ACT_CLEAR);
				random_gap();
			end
			random_other(ACT_DUMP);
			random_gap();
		end
		start <= 1'b0;

		while (book.pending.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
		if (book.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sorted_dedup_event_list.f =====
hw/rtl/sdel_pkg.sv
hw/rtl/sdel_cell.sv
hw/rtl/sorted_dedup_event_list.sv
tb/sv/tb.sv
